// File: rtl/core/dda3_pkg.sv
// shared constants and control types for the 3d integer dda ray stepper
// no dependencies
package dda3_pkg;

  // default coordinate width
  localparam int CoordBitsDef = 12;

  // input command codes
  localparam logic CmdStart = 1'b0;
  localparam logic CmdStep  = 1'b1;

  // commands from the controller to the datapath
  typedef struct packed {
    logic latch;     // register the input item
    logic setup;     // deltas, span and step count from the endpoints
    logic scale;     // accumulators set to source times span
    logic advance;   // count a step, move the accumulators, load the dividers
    logic div_step;  // one restoring division step in every lane
    logic load_out;  // write the output register
    logic out_zero;  // written result is the all-zero one
  } ctrl_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic live;      // stepped count still below the span
  } dp_stat_t;

endpackage

// File: rtl/core/dda3_if.sv
// valid/ready channel interfaces for the 3d integer dda ray stepper
// depends on dda3_pkg
interface dda3_in_if #(
  parameter int COORD_BITS = dda3_pkg::CoordBitsDef
) ();
  logic                  valid;
  logic                  ready;
  logic                  cmd;
  logic [COORD_BITS-1:0] src_x;
  logic [COORD_BITS-1:0] src_y;
  logic [COORD_BITS-1:0] src_z;
  logic [COORD_BITS-1:0] dst_x;
  logic [COORD_BITS-1:0] dst_y;
  logic [COORD_BITS-1:0] dst_z;

  modport source (
    output valid, cmd, src_x, src_y, src_z, dst_x, dst_y, dst_z,
    input  ready
  );
  modport sink (
    input  valid, cmd, src_x, src_y, src_z, dst_x, dst_y, dst_z,
    output ready
  );
endinterface

interface dda3_out_if #(
  parameter int COORD_BITS = dda3_pkg::CoordBitsDef
) ();
  logic                valid;
  logic                ready;
  logic                step_valid;
  logic [COORD_BITS-1:0] floor_x;
  logic [COORD_BITS-1:0] floor_y;
  logic [COORD_BITS-1:0] floor_z;
  logic [COORD_BITS:0]   ceil_x;
  logic [COORD_BITS:0]   ceil_y;
  logic [COORD_BITS:0]   ceil_z;

  modport source (
    output valid, step_valid, floor_x, floor_y, floor_z, ceil_x, ceil_y, ceil_z,
    input  ready
  );
  modport sink (
    input  valid, step_valid, floor_x, floor_y, floor_z, ceil_x, ceil_y, ceil_z,
    output ready
  );
endinterface

// File: rtl/core/dda3_ctrl.sv
// controller state machine of the 3d integer dda ray stepper
// depends on dda3_pkg; drives dda3_dpath through ctrl_cmd_t
module dda3_ctrl #(
  parameter int COORD_BITS = dda3_pkg::CoordBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_cmd_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output dda3_pkg::ctrl_cmd_t   cmd_o,
  input  dda3_pkg::dp_stat_t    stat_i
);

  localparam int DivCntW = $clog2(COORD_BITS);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StSetup = 3'd1;
  localparam logic [2:0] StScale = 3'd2;
  localparam logic [2:0] StAdv   = 3'd3;
  localparam logic [2:0] StDiv   = 3'd4;
  localparam logic [2:0] StDone  = 3'd5;

  logic [2:0]         state_q, state_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               zero_q, zero_d;
  logic               out_valid_q, out_valid_d;
  dda3_pkg::ctrl_cmd_t cmd;

  always_comb begin
    cmd     = '0;
    state_d = state_q;
    cnt_d   = cnt_q;
    zero_d  = zero_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd.latch = 1'b1;
          state_d   = (in_cmd_i == dda3_pkg::CmdStep) ? StAdv : StSetup;
        end
      end
      StSetup: begin
        cmd.setup = 1'b1;
        state_d   = StScale;
      end
      StScale: begin
        cmd.scale = 1'b1;
        zero_d    = 1'b1;
        state_d   = StDone;
      end
      StAdv: begin
        cmd.advance = 1'b1;
        if (stat_i.live) begin
          zero_d  = 1'b0;
          cnt_d   = DivCntW'(COORD_BITS - 1);
          state_d = StDiv;
        end else begin
          zero_d  = 1'b1;
          state_d = StDone;
        end
      end
      StDiv: begin
        cmd.div_step = 1'b1;
        cnt_d        = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = StDone;
        end
      end
      StDone: begin
        // wait for the output register to free up
        if (!out_valid_q || out_ready_i) begin
          cmd.load_out = 1'b1;
          cmd.out_zero = zero_q;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      zero_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      zero_q      <= zero_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

`ifndef NO_ASSERTIONS
  // an accepted item always leaves idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle && in_valid_i) |=> (state_q != StIdle))
    else $error("dda3_ctrl: accepted item did not start work");

  // a waiting result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!out_valid_q || out_ready_i))
    else $error("dda3_ctrl: output register overwritten");

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> out_valid_q)
    else $error("dda3_ctrl: stalled result dropped");

  // division always runs the full count before the result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv && cnt_q != '0) |=> (state_q == StDiv))
    else $error("dda3_ctrl: division cut short");
`endif

endmodule

// File: rtl/core/dda3_dpath.sv
// datapath of the 3d integer dda ray stepper: endpoint setup, accumulators,
// three restoring divider lanes and the output register; depends on dda3_pkg
module dda3_dpath #(
  parameter int COORD_BITS = dda3_pkg::CoordBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dda3_pkg::ctrl_cmd_t   cmd_i,
  output dda3_pkg::dp_stat_t    stat_o,
  input  logic [COORD_BITS-1:0] src_i   [3],
  input  logic [COORD_BITS-1:0] dst_i   [3],
  output logic                  step_valid_o,
  output logic [COORD_BITS-1:0] floor_o [3],
  output logic [COORD_BITS:0]   ceil_o  [3]
);

  localparam int CB = COORD_BITS;
  localparam int DW = CB + 1;
  localparam int AW = 2 * CB + 2;

  logic [CB-1:0] src_q   [3];
  logic [CB-1:0] dst_q   [3];
  logic [DW-1:0] delta_q [3];
  logic [AW-1:0] acc_q   [3];
  logic [CB-1:0] rem_q   [3];
  logic [CB-1:0] num_q   [3];
  logic [CB-1:0] floor_q [3];
  logic [CB:0]   ceil_q  [3];
  logic          step_valid_q;
  logic [CB-1:0] span_q;
  logic [DW-1:0] cnt_q;

  logic [DW-1:0]   diff    [3];
  logic [CB-1:0]   mag     [3];
  logic [AW-1:0]   acc_sum [3];
  logic [2*CB-1:0] prod    [3];
  logic [CB-1:0]   rem_d   [3];
  logic [CB-1:0]   num_d   [3];
  logic [CB-1:0]   span_max;
  logic [DW-1:0]   cnt_inc;
  logic            live;

  always_comb begin
    span_max = mag[0];
    if (mag[1] > span_max) begin
      span_max = mag[1];
    end
    if (mag[2] > span_max) begin
      span_max = mag[2];
    end
  end

  // step count saturates at all ones
  assign cnt_inc     = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;
  assign live        = (cnt_inc < {1'b0, span_q});
  assign stat_o.live = live;

  for (genvar g = 0; g < 3; g++) begin : g_lane
    logic [CB:0] trial;
    logic        ge;

    assign diff[g]    = {1'b0, dst_q[g]} - {1'b0, src_q[g]};
    assign mag[g]     = (dst_q[g] >= src_q[g]) ? dst_q[g] - src_q[g] : src_q[g] - dst_q[g];
    assign prod[g]    = {{CB{1'b0}}, src_q[g]} * {{CB{1'b0}}, span_q};
    assign acc_sum[g] = acc_q[g] + {{(AW - DW){delta_q[g][DW-1]}}, delta_q[g]};

    // restoring step: the partial remainder stays below the span, so the
    // top part of the accumulator on a live ray fits in cb bits
    assign trial    = {rem_q[g], num_q[g][CB-1]};
    assign ge       = (trial >= {1'b0, span_q});
    assign rem_d[g] = ge ? CB'(trial - {1'b0, span_q}) : trial[CB-1:0];
    assign num_d[g] = {num_q[g][CB-2:0], ge};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        delta_q[g] <= '0;
        acc_q[g]   <= '0;
      end else begin
        if (cmd_i.setup) begin
          delta_q[g] <= diff[g];
        end
        if (cmd_i.scale) begin
          acc_q[g] <= {2'b00, prod[g]};
        end else if (cmd_i.advance && live) begin
          acc_q[g] <= acc_sum[g];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.latch) begin
        src_q[g] <= src_i[g];
        dst_q[g] <= dst_i[g];
      end
      if (cmd_i.advance) begin
        rem_q[g] <= acc_sum[g][2*CB-1:CB];
        num_q[g] <= acc_sum[g][CB-1:0];
      end else if (cmd_i.div_step) begin
        rem_q[g] <= rem_d[g];
        num_q[g] <= num_d[g];
      end
      if (cmd_i.load_out) begin
        if (cmd_i.out_zero) begin
          floor_q[g] <= '0;
          ceil_q[g]  <= '0;
        end else begin
          // ceiling is the quotient, plus one for a nonzero remainder
          floor_q[g] <= num_q[g];
          ceil_q[g]  <= {1'b0, num_q[g]} + {{CB{1'b0}}, (rem_q[g] != '0)};
        end
      end
    end

    assign floor_o[g] = floor_q[g];
    assign ceil_o[g]  = ceil_q[g];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      span_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (cmd_i.setup) begin
        span_q <= span_max;
        cnt_q  <= '0;
      end else if (cmd_i.advance) begin
        cnt_q <= cnt_inc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      step_valid_q <= !cmd_i.out_zero;
    end
  end

  assign step_valid_o = step_valid_q;

endmodule

// File: rtl/core/integer_dda_ray_stepper_3d.sv
// 3d integer dda ray stepper: walks a voxel line between two endpoints
// depends on dda3_pkg, dda3_if, dda3_ctrl and dda3_dpath
//
// usage:
//   in_i carries one command per transfer: cmd start loads source and
//   target, cmd step advances the ray by one step. out_o returns exactly
//   one result per command. a start result, and a step at or past the end
//   of the ray, has step_valid low and all coordinates zero; a step strictly
//   inside the ray gives the floor and ceiling voxel of the scaled position.
//   a start passes the setup, scale and done states before its result is
//   valid, a finished step advance and done, a live step advance, the division steps and done.
//   one item is worked on at a time and the next is taken once the result
//   sits in the output register; the length of a live step's work
//   is set by the three restoring divider lanes, one quotient bit per
//   cycle each. a result waiting on a stalled receiver is held in the
//   output register; the next item is still taken and its result waits
//   until that register frees up. reset clears the ray to zero span, so
//   every step before the first start is a finished step.
module integer_dda_ray_stepper_3d #(
  parameter int COORD_BITS = dda3_pkg::CoordBitsDef
) (
  input logic        clk_i,
  input logic        rst_ni,
  dda3_in_if.sink    in_i,
  dda3_out_if.source out_o
);

  dda3_pkg::ctrl_cmd_t   cmd;
  dda3_pkg::dp_stat_t    stat;
  logic [COORD_BITS-1:0] src   [3];
  logic [COORD_BITS-1:0] dst   [3];
  logic [COORD_BITS-1:0] floor_v [3];
  logic [COORD_BITS:0]   ceil_v  [3];

  assign src[0] = in_i.src_x;
  assign src[1] = in_i.src_y;
  assign src[2] = in_i.src_z;
  assign dst[0] = in_i.dst_x;
  assign dst[1] = in_i.dst_y;
  assign dst[2] = in_i.dst_z;

  dda3_ctrl #(
    .COORD_BITS (COORD_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_cmd_i    (in_i.cmd),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  dda3_dpath #(
    .COORD_BITS (COORD_BITS)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .src_i        (src),
    .dst_i        (dst),
    .step_valid_o (out_o.step_valid),
    .floor_o      (floor_v),
    .ceil_o       (ceil_v)
  );

  assign out_o.floor_x = floor_v[0];
  assign out_o.floor_y = floor_v[1];
  assign out_o.floor_z = floor_v[2];
  assign out_o.ceil_x  = ceil_v[0];
  assign out_o.ceil_y  = ceil_v[1];
  assign out_o.ceil_z  = ceil_v[2];

endmodule
